/* src/standoff_goal_from_target_unit_macros.svh */
// assertion helpers for the standoff goal unit
`ifndef STANDOFF_GOAL_FROM_TARGET_UNIT_MACROS_SVH
`define STANDOFF_GOAL_FROM_TARGET_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SOFG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SOFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sofg_pkg.sv */
package sofg_pkg;

  // full-scale value of a Q1.15 quaternion term
  localparam logic [15:0] QUAT_ONE = 16'h7fff;

  // pre-shift of r +/- x before dividing by r (result in Q2.30 of the square)
  localparam int HALF_ANGLE_SHIFT = 29;

  // target magnitudes and signs carried along the range square root
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic        xneg;
    logic        yneg;
  } sofg_geo_t;

  // per-transaction flags carried through the divider and half-angle root
  typedef struct packed {
    logic close;
    logic xneg;
    logic yneg;
    logic rzero;
  } sofg_flags_t;

  // what the half-angle root carries to the output stage
  typedef struct packed {
    sofg_flags_t flags;
    logic [31:0] gx_mag;
    logic [31:0] gy_mag;
  } sofg_fin_t;

endpackage

/* src/sofg_isqrt.sv */
module sofg_isqrt #(
  parameter int VW    = 64,
  parameter int LANES = 1,
  parameter int TW    = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [LANES-1:0][VW-1:0]          in_val,
  input  logic [TW-1:0]                     in_tag,
  output logic                              out_valid,
  output logic [LANES-1:0][VW/2-1:0]        out_root,
  output logic [TW-1:0]                     out_tag
);

  localparam int RW    = VW / 2;
  localparam int STEPS = RW;
  localparam int EW    = RW + 2;

  // one result bit per stage, digit-by-digit
  logic [STEPS-1:0]              vld_r;
  logic [LANES-1:0][VW-1:0]      rad_r  [STEPS];
  logic [LANES-1:0][EW-1:0]      rem_r  [STEPS];
  logic [LANES-1:0][RW-1:0]      root_r [STEPS];
  logic [TW-1:0]                 tag_r  [STEPS];

  logic [LANES-1:0][VW-1:0]      rad_nxt  [STEPS];
  logic [LANES-1:0][EW-1:0]      rem_nxt  [STEPS];
  logic [LANES-1:0][RW-1:0]      root_nxt [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic                         pv;
    logic [TW-1:0]                ptag;
    logic [LANES-1:0][VW-1:0]     prad;
    logic [LANES-1:0][EW-1:0]     prem;
    logic [LANES-1:0][RW-1:0]     proot;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign ptag  = in_tag;
      assign prad  = in_val;
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_next
      assign pv    = vld_r[s-1];
      assign ptag  = tag_r[s-1];
      assign prad  = rad_r[s-1];
      assign prem  = rem_r[s-1];
      assign proot = root_r[s-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      logic [EW+1:0] t;
      logic [EW+1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        t     = {prem[l], prad[l][VW-1:VW-2]};
        trial = {{(EW-RW){1'b0}}, proot[l], 2'b01};
        rad_nxt[s][l] = {prad[l][VW-3:0], 2'b00};
        if (t >= trial) begin
          rem_nxt[s][l]  = EW'(t - trial);
          root_nxt[s][l] = {proot[l][RW-2:0], 1'b1};
        end else begin
          rem_nxt[s][l]  = EW'(t);
          root_nxt[s][l] = {proot[l][RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s]  <= ptag;
        rad_r[s]  <= rad_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_tag   = tag_r[STEPS-1];

endmodule

/* src/sofg_div.sv */
module sofg_div #(
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int LANES = 4,
  parameter int TW    = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [LANES-1:0][DW+QW-1:0]       in_num,
  input  logic [DW-1:0]                     in_den,
  input  logic [TW-1:0]                     in_tag,
  output logic                              out_valid,
  output logic [LANES-1:0][QW-1:0]          out_quot,
  output logic [TW-1:0]                     out_tag
);

  localparam int NW = DW + QW;

  // restoring division, one quotient bit per stage; the top part of the
  // numerator is below the divisor, so the partial remainder stays DW wide
  logic [QW-1:0]                 vld_r;
  logic [LANES-1:0][DW-1:0]      rem_r [QW];
  logic [LANES-1:0][QW-1:0]      nq_r  [QW];
  logic [DW-1:0]                 den_r [QW];
  logic [TW-1:0]                 tag_r [QW];

  logic [LANES-1:0][DW-1:0]      rem_nxt [QW];
  logic [LANES-1:0][QW-1:0]      nq_nxt  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic                         pv;
    logic [TW-1:0]                ptag;
    logic [DW-1:0]                pden;
    logic [LANES-1:0][DW-1:0]     prem;
    logic [LANES-1:0][QW-1:0]     pnq;

    if (s == 0) begin : g_first
      assign pv   = in_valid;
      assign ptag = in_tag;
      assign pden = in_den;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign prem[l] = in_num[l][NW-1:QW];
        assign pnq[l]  = in_num[l][QW-1:0];
      end
    end else begin : g_next
      assign pv   = vld_r[s-1];
      assign ptag = tag_r[s-1];
      assign pden = den_r[s-1];
      assign prem = rem_r[s-1];
      assign pnq  = nq_r[s-1];
    end

    // shift in the next numerator bit and subtract when it fits
    always_comb begin
      logic [DW:0] t;
      for (int l = 0; l < LANES; l++) begin
        t = {prem[l], pnq[l][QW-1]};
        if (t >= {1'b0, pden}) begin
          rem_nxt[s][l] = DW'(t - {1'b0, pden});
          nq_nxt[s][l]  = {pnq[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = t[DW-1:0];
          nq_nxt[s][l]  = {pnq[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s] <= ptag;
        den_r[s] <= pden;
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = nq_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule

/* src/standoff_goal_from_target_unit.sv */
// pipeline: 3 front stages, 32-stage range square root, 2 prep stages, 32-stage
//   divider, 16-stage half-angle root, output register
// throughput: one transaction per cycle; a stalled output freezes the whole pipe
// reset: synchronous active-low rst_n clears all valid bits and sets the
//   standoff distance to zero
module standoff_goal_from_target_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_goal_x,
  output logic signed [31:0] out_goal_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic               out_too_close
);

  import sofg_pkg::*;

  `include "standoff_goal_from_target_unit_macros.svh"

  localparam int EW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  logic        adv;
  logic [30:0] standoff_r;

  // pipeline moves whenever the output register can take a transaction
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // standoff register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      standoff_r <= '0;
    end else if (cfg_we) begin
      standoff_r <= cfg_wdata;
    end
  end

  // sign-extend the inputs and take magnitudes
  logic signed [32:0] xe, ye;
  logic [32:0]        xneg_val, yneg_val;

  assign xe       = signed'({{(33 - EW){in_target_x[EW-1]}}, in_target_x[EW-1:0]});
  assign ye       = signed'({{(33 - EW){in_target_y[EW-1]}}, in_target_y[EW-1:0]});
  assign xneg_val = 33'(-xe);
  assign yneg_val = 33'(-ye);

  logic        v0_r;
  sofg_geo_t   geo0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo0_r.xneg <= xe[32];
      geo0_r.yneg <= ye[32];
      geo0_r.ax   <= xe[32] ? xneg_val[31:0] : xe[31:0];
      geo0_r.ay   <= ye[32] ? yneg_val[31:0] : ye[31:0];
    end
  end

  // squares
  logic        v1_r;
  sofg_geo_t   geo1_r;
  logic [63:0] sqx1_r, sqy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo1_r <= geo0_r;
      sqx1_r <= 64'(geo0_r.ax) * 64'(geo0_r.ay ^ geo0_r.ay ^ geo0_r.ax);
      sqy1_r <= 64'(geo0_r.ay) * 64'(geo0_r.ay);
    end
  end

  // sum of squares
  logic        v2_r;
  sofg_geo_t   geo2_r;
  logic [63:0] sum2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo2_r <= geo1_r;
      sum2_r <= sqx1_r + sqy1_r;
    end
  end

  // range square root
  logic                        rng_valid;
  logic [0:0][31:0]            rng_root;
  logic [$bits(sofg_geo_t)-1:0] rng_tag;
  sofg_geo_t                   geo_s;

  sofg_isqrt #(
    .VW    (64),
    .LANES (1),
    .TW    ($bits(sofg_geo_t))
  ) u_range_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v2_r),
    .in_val    (sum2_r),
    .in_tag    (geo2_r),
    .out_valid (rng_valid),
    .out_root  (rng_root),
    .out_tag   (rng_tag)
  );

  assign geo_s = sofg_geo_t'(rng_tag);

  // compare with the standoff, form r - d and r +/- x
  logic        v3_r;
  sofg_geo_t   geo3_r;
  logic        close3_r;
  logic [31:0] r3_r, dm3_r;
  logic [32:0] rp3_r, rm3_r;
  logic [32:0] r_ext, ax_ext;

  assign r_ext  = {1'b0, rng_root[0]};
  assign ax_ext = {1'b0, geo_s.ax};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= rng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo3_r   <= geo_s;
      r3_r     <= rng_root[0];
      close3_r <= rng_root[0] <= {1'b0, standoff_r};
      dm3_r    <= rng_root[0] - {1'b0, standoff_r};
      rp3_r    <= geo_s.xneg ? (r_ext - ax_ext) : (r_ext + ax_ext);
      rm3_r    <= geo_s.xneg ? (r_ext + ax_ext) : (r_ext - ax_ext);
    end
  end

  // scaling products and half-angle numerators
  logic                    v4_r;
  sofg_flags_t             flg4_r;
  logic [31:0]             r4_r;
  logic [3:0][63:0]        num4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_r         <= r3_r;
      flg4_r.close <= close3_r;
      flg4_r.xneg  <= geo3_r.xneg;
      flg4_r.yneg  <= geo3_r.yneg;
      flg4_r.rzero <= (r3_r == '0);
      num4_r[0]    <= 64'(geo3_r.ax) * 64'(dm3_r);
      num4_r[1]    <= 64'(geo3_r.ay) * 64'(dm3_r);
      num4_r[2]    <= {2'b00, rp3_r, {HALF_ANGLE_SHIFT{1'b0}}};
      num4_r[3]    <= {2'b00, rm3_r, {HALF_ANGLE_SHIFT{1'b0}}};
    end
  end

  // all four divisions by r share one divider pipe
  logic                          div_valid;
  logic [3:0][31:0]              div_quot;
  logic [$bits(sofg_flags_t)-1:0] div_tag;

  sofg_div #(
    .DW    (32),
    .QW    (32),
    .LANES (4),
    .TW    ($bits(sofg_flags_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v4_r),
    .in_num    (num4_r),
    .in_den    (r4_r),
    .in_tag    (flg4_r),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_tag   (div_tag)
  );

  // half-angle square roots
  sofg_fin_t                    fin_in;
  logic                         ha_valid;
  logic [1:0][15:0]             ha_root;
  logic [$bits(sofg_fin_t)-1:0] ha_tag;
  sofg_fin_t                    fin_s;

  assign fin_in.flags  = sofg_flags_t'(div_tag);
  assign fin_in.gx_mag = div_quot[0];
  assign fin_in.gy_mag = div_quot[1];

  sofg_isqrt #(
    .VW    (32),
    .LANES (2),
    .TW    ($bits(sofg_fin_t))
  ) u_half_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (div_valid),
    .in_val    ({div_quot[3], div_quot[2]}),
    .in_tag    (fin_in),
    .out_valid (ha_valid),
    .out_root  (ha_root),
    .out_tag   (ha_tag)
  );

  assign fin_s = sofg_fin_t'(ha_tag);

  // output register
  logic        out_valid_r;
  logic [31:0] gx_r, gy_r;
  logic [15:0] qz_r, qw_r;
  logic        close_r;
  logic [15:0] w_sat, z_sat;

  assign w_sat = ha_root[0][15] ? QUAT_ONE : ha_root[0];
  assign z_sat = ha_root[1][15] ? QUAT_ONE : ha_root[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ha_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      close_r <= fin_s.flags.close;
      if (fin_s.flags.close) begin
        gx_r <= '0;
        gy_r <= '0;
      end else begin
        gx_r <= fin_s.flags.xneg ? 32'(-fin_s.gx_mag) : fin_s.gx_mag;
        gy_r <= fin_s.flags.yneg ? 32'(-fin_s.gy_mag) : fin_s.gy_mag;
      end
      // zero range gives the identity orientation
      if (fin_s.flags.rzero) begin
        qz_r <= '0;
        qw_r <= QUAT_ONE;
      end else begin
        qz_r <= fin_s.flags.yneg ? 16'(-ha_root[1]) : z_sat;
        qw_r <= w_sat;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_goal_x    = signed'(gx_r);
  assign out_goal_y    = signed'(gy_r);
  assign out_quat_z    = signed'(qz_r);
  assign out_quat_w    = signed'(qw_r);
  assign out_too_close = close_r;

  // checks
  `SOFG_ASSERT_NOW(a_close_zero_goal, out_valid && out_too_close, (out_goal_x == '0) && (out_goal_y == '0), "too-close result with nonzero goal")
  `SOFG_ASSERT_NOW(a_quat_w_nonneg, out_valid, !out_quat_w[15], "negative quat_w")
  `SOFG_ASSERT_NEXT(a_stall_freezes_pipe, out_valid && out_stall, out_valid && (v0_r == $past(v0_r)), "pipeline moved under output stall")

endmodule

/* bench/standoff_goal_from_target_unit_test.sv */
`timescale 1ns / 1ps

module standoff_goal_from_target_unit_test;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               too_close;
  } goal_t;

  // directed row: target, optional typed-in result
  typedef struct {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic               typed;
    goal_t              res;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [30:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_target_x;
  logic signed [31:0] in_target_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_goal_x;
  logic signed [31:0] out_goal_y;
  logic signed [15:0] out_quat_z;
  logic signed [15:0] out_quat_w;
  logic               out_too_close;

  logic [30:0] standoff_q;
  goal_t       pending_goals[$];
  int          fail_count;
  bit          drain_done;

  standoff_goal_from_target_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_target_x  (in_target_x),
    .in_target_y  (in_target_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_goal_x   (out_goal_x),
    .out_goal_y   (out_goal_y),
    .out_quat_z   (out_quat_z),
    .out_quat_w   (out_quat_w),
    .out_too_close(out_too_close)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Test completed with failures");
    $finish;
  end

  // bitwise integer square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // range, pulled-back goal and half-bearing quaternion terms
  function automatic goal_t standoff_goal(input logic signed [31:0] tx,
                                          input logic signed [31:0] ty,
                                          input logic [30:0] standoff_val);
    goal_t g;
    logic [63:0] ax, ay, rng, d, mag, wv, zv;
    ax = tx[31] ? -{{32{tx[31]}}, tx} : {32'd0, tx};
    ay = ty[31] ? -{{32{ty[31]}}, ty} : {32'd0, ty};
    rng = floor_sqrt(ax * ax + ay * ay);
    d = {33'd0, standoff_val};
    g.too_close = (rng <= d);
    g.goal_x = 0;
    g.goal_y = 0;
    g.quat_z = 0;
    g.quat_w = 16'sh7fff;
    if (!g.too_close) begin
      mag = ax * (rng - d) / rng;
      g.goal_x = tx[31] ? -mag[31:0] : mag[31:0];
      mag = ay * (rng - d) / rng;
      g.goal_y = ty[31] ? -mag[31:0] : mag[31:0];
    end
    if (rng != 0) begin
      wv = floor_sqrt(((rng + {{32{tx[31]}}, tx}) << 29) / rng);
      zv = floor_sqrt(((rng - {{32{tx[31]}}, tx}) << 29) / rng);
      if (wv > 32767) wv = 32767;
      if (ty[31]) begin
        g.quat_z = -zv[15:0];
      end else begin
        if (zv > 32767) zv = 32767;
        g.quat_z = zv[15:0];
      end
      g.quat_w = wv[15:0];
    end
    return g;
  endfunction

  // send one target transaction after a random gap; valid stays up after
  // acceptance so back-to-back transactions need no second assignment
  task automatic send_target(input logic signed [31:0] tx, input logic signed [31:0] ty,
                             input logic typed, input goal_t res);
    int gap;
    goal_t g;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_x <= tx;
    in_target_y <= ty;
    g = standoff_goal(tx, ty, standoff_q);
    if (typed) begin
      if (g != res) begin
        $display("%0t typed row x=%0d y=%0d exp %h got %h", $time, tx, ty, res, g);
        fail_count++;
      end
      g = res;
    end
    pending_goals.push_back(g);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for idle, then write the standoff register
  task automatic set_standoff(input logic [30:0] standoff_val);
    in_valid <= 1'b0;
    while (pending_goals.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= standoff_val;
    standoff_q = standoff_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 65535 * 8)) - 32'sd262140;
      2: return $signed($urandom_range(0, 2000)) - 32'sd1000;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom) >>> $urandom_range(0, 30);
    endcase
  endfunction

  // result stall generator
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      out_stall <= hold != 0;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    goal_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_goals.size() == 0) begin
        $display("%0t unexpected result goal_x=%0d", $time, out_goal_x);
        fail_count++;
      end else begin
        g = pending_goals.pop_front();
        if (out_goal_x !== g.goal_x) begin
          $display("%0t goal_x exp %0d got %0d", $time, g.goal_x, out_goal_x);
          fail_count++;
        end
        if (out_goal_y !== g.goal_y) begin
          $display("%0t goal_y exp %0d got %0d", $time, g.goal_y, out_goal_y);
          fail_count++;
        end
        if (out_quat_z !== g.quat_z) begin
          $display("%0t quat_z exp %0d got %0d", $time, g.quat_z, out_quat_z);
          fail_count++;
        end
        if (out_quat_w !== g.quat_w) begin
          $display("%0t quat_w exp %0d got %0d", $time, g.quat_w, out_quat_w);
          fail_count++;
        end
        if (out_too_close !== g.too_close) begin
          $display("%0t too_close exp %0b got %0b", $time, g.too_close, out_too_close);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t  rows[$];
    row_t  r;
    goal_t none;
    int    wait_cycles;
    logic [30:0] dists[6];
    none = '{0, 0, 0, 0, 0};
    fail_count = 0;
    standoff_q = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 0;
    in_valid = 1'b0;
    in_target_x = 0;
    in_target_y = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: zero, straight behind, axes, extremes, unit diagonals, 3-4-5
    rows.push_back('{0, 0, 1, '{0, 0, 16'sd0, 16'sh7fff, 1'b1}});
    rows.push_back('{-32'sd65536, 0, 1, '{-32'sd65536, 0, 16'sh7fff, 16'sd0, 1'b0}});
    rows.push_back('{32'sd65536, 0, 1, '{32'sd65536, 0, 16'sd0, 16'sh7fff, 1'b0}});
    rows.push_back('{0, 32'sd65536, 0, none});
    rows.push_back('{0, -32'sd65536, 0, none});
    rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 0, none});
    rows.push_back('{32'sh80000000, 32'sh80000000, 0, none});
    rows.push_back('{32'sh80000000, 0, 0, none});
    rows.push_back('{32'sh7fffffff, 32'sh80000000, 0, none});
    rows.push_back('{1, -1, 0, none});
    rows.push_back('{-1, 1, 0, none});
    rows.push_back('{32'sd196608, 32'sd262144, 0, none});
    foreach (rows[i]) send_target(rows[i].tx, rows[i].ty, rows[i].typed, rows[i].res);

    // range equal to standoff (3-4-5), a larger range and the zero target
    set_standoff(31'd327680);
    send_target(32'sd196608, 32'sd262144, 1'b0, none);
    send_target(32'sd196608, -32'sd262144, 1'b0, none);
    send_target(32'sd393216, 32'sd524288, 1'b0, none);
    send_target(0, 0, 1'b1, '{0, 0, 16'sd0, 16'sh7fff, 1'b1});

    // random phases across standoff settings
    dists = '{31'd0, 31'h7fffffff, 31'd65536, 31'd327680, 31'd1000, 31'd0};
    for (int p = 0; p < 6; p++) begin
      set_standoff(p == 5 ? 31'($urandom) : dists[p]);
      for (int k = 0; k < 150; k++) send_target(rand_coord(), rand_coord(), 1'b0, none);
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_goals.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_goals.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
